[sv/b64e_pkg.sv]
package b64e_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [5:0] SEXTET_LOWER_START = 6'd26;
  localparam logic [5:0] SEXTET_DIGIT_START = 6'd52;
  localparam logic [5:0] SEXTET_PLUS = 6'd62;

  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
  localparam logic [7:0] CHAR_PLUS = 8'h2B;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_PAD = 8'h3D;

  localparam logic [1:0] POS_FIRST = 2'd0;
  localparam logic [1:0] POS_SECOND = 2'd1;
  localparam logic [1:0] POS_THIRD = 2'd2;

  // One accepted byte turned into the characters it causes. Characters at
  // index two and three, when present, are always padding.
  typedef struct packed {
    logic [5:0] sextet0;
    logic [5:0] sextet1;
    logic [1:0] last_idx;
    logic       last;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } job_req_t;

  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    logic [7:0] c;
    if (v < SEXTET_LOWER_START) begin
      c = CHAR_UPPER_A + {2'b00, v};
    end else if (v < SEXTET_DIGIT_START) begin
      c = CHAR_LOWER_A + {2'b00, v - SEXTET_LOWER_START};
    end else if (v < SEXTET_PLUS) begin
      c = CHAR_DIGIT_0 + {2'b00, v - SEXTET_DIGIT_START};
    end else if (v == SEXTET_PLUS) begin
      c = CHAR_PLUS;
    end else begin
      c = CHAR_SLASH;
    end
    return c;
  endfunction

endpackage

[sv/b64e_byte_if.sv]
interface b64e_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

[sv/b64e_char_if.sv]
interface b64e_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       out_last;

  modport source (output valid, output out_char, output out_last, input ready);
  modport sink (input valid, input out_char, input out_last, output ready);
endinterface

[sv/base64_stream_encoder.sv]
// Streaming Base64 encoder with the standard alphabet and '=' padding, no
// line wrapping. A byte is taken in every cycle while the job queue between
// the input and output sides has room, and characters leave from a
// registered output at one per cycle while the receiver is ready. Each byte
// becomes one or two characters, and the byte marked last becomes up to four
// with padding, so the output port sets the sustained rate. An accepted byte
// is written into the job queue and then loaded into the registered output
// before its first character leaves.
module base64_stream_encoder
  import b64e_pkg::*;
#(
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  b64e_byte_if.sink   byte_i,
  b64e_char_if.source char_o
);

  job_req_t push, pop;
  logic     push_ready, pop_take;

  b64e_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .byte_i      (byte_i),
    .push_ready_i(push_ready),
    .push_o      (push)
  );

  b64e_fifo #(
    .DEPTH(QueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_ready_o(push_ready),
    .pop_o       (pop),
    .pop_i       (pop_take)
  );

  b64e_back u_back (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .pop_i (pop),
    .pop_o (pop_take),
    .char_o(char_o)
  );

endmodule

[sv/b64e_front.sv]
module b64e_front
  import b64e_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  b64e_byte_if.sink byte_i,
  input  logic      push_ready_i,
  output job_req_t  push_o
);

  logic [1:0] pos_q, pos_d;
  logic [3:0] left_q, left_d;
  logic       accept;
  job_t       job;

  assign byte_i.ready = push_ready_i;
  assign accept = byte_i.valid && push_ready_i;

  always_comb begin
    job.last = byte_i.in_last;
    case (pos_q)
      POS_SECOND: begin
        job.sextet0 = {left_q[1:0], byte_i.in_byte[7:4]};
        job.sextet1 = {byte_i.in_byte[3:0], 2'b00};
        job.last_idx = byte_i.in_last ? 2'd2 : 2'd0;
        pos_d = POS_THIRD;
        left_d = byte_i.in_byte[3:0];
      end
      POS_THIRD: begin
        job.sextet0 = {left_q, byte_i.in_byte[7:6]};
        job.sextet1 = byte_i.in_byte[5:0];
        job.last_idx = 2'd1;
        pos_d = POS_FIRST;
        left_d = 4'd0;
      end
      default: begin
        job.sextet0 = byte_i.in_byte[7:2];
        job.sextet1 = {byte_i.in_byte[1:0], 4'b0000};
        job.last_idx = byte_i.in_last ? 2'd3 : 2'd0;
        pos_d = POS_SECOND;
        left_d = {2'b00, byte_i.in_byte[1:0]};
      end
    endcase
    if (byte_i.in_last) begin
      pos_d = POS_FIRST;
      left_d = 4'd0;
    end
  end

  assign push_o.valid = accept;
  assign push_o.job = job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= POS_FIRST;
      left_q <= 4'd0;
    end else if (accept) begin
      pos_q <= pos_d;
      left_q <= left_d;
    end
  end

endmodule

[sv/b64e_fifo.sv]
module b64e_fifo
  import b64e_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  job_req_t push_i,
  output logic     push_ready_o,
  output job_req_t pop_o,
  input  logic     pop_i
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  job_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             do_push, do_pop;

  assign push_ready_o = (count_q != CNT_FULL);
  assign do_push = push_i.valid && push_ready_o;
  assign do_pop = pop_i && pop_o.valid;
  assign pop_o.valid = (count_q != '0);
  assign pop_o.job = mem[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[wr_ptr_q] <= push_i.job;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

[sv/b64e_back.sv]
module b64e_back
  import b64e_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  job_req_t    pop_i,
  output logic        pop_o,
  b64e_char_if.source char_o
);

  logic [1:0] idx_q;
  logic       out_valid_q;
  logic [7:0] out_char_q, out_char_d;
  logic       out_last_q, out_last_d;
  logic       load, emit, job_done;

  assign load = !out_valid_q || char_o.ready;
  assign emit = load && pop_i.valid;
  assign job_done = (idx_q == pop_i.job.last_idx);
  assign pop_o = emit && job_done;

  always_comb begin
    case (idx_q)
      2'd0: out_char_d = sextet_char(pop_i.job.sextet0);
      2'd1: out_char_d = sextet_char(pop_i.job.sextet1);
      default: out_char_d = CHAR_PAD;
    endcase
    out_last_d = pop_i.job.last && job_done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        out_valid_q <= pop_i.valid;
      end
      if (emit) begin
        idx_q <= job_done ? 2'd0 : idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_char_q <= out_char_d;
      out_last_q <= out_last_d;
    end
  end

  assign char_o.valid = out_valid_q;
  assign char_o.out_char = out_char_q;
  assign char_o.out_last = out_last_q;

endmodule

[verif/tb.sv]
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import b64e_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned RANDOM_BYTES = 400;
  localparam int unsigned TAIL_CYCLES = 16;

  typedef struct {
    logic [7:0]  data;
    logic        fin;
    int unsigned gap;
    bit          drain;
  } byte_req_t;

  typedef struct {
    logic [7:0] ch;
    logic       fin;
  } b64_char_t;

  logic clk = 1'b0;
  logic rst_n;

  b64e_byte_if byte_if ();
  b64e_char_if char_if ();

  base64_stream_encoder dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .byte_i(byte_if),
    .char_o(char_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  byte_req_t   byte_queue[$];
  b64_char_t   chars_due[$];
  logic [1:0]  grp_pos = POS_FIRST;
  logic [3:0]  carry_bits = 4'd0;
  bit          in_flight;
  int unsigned gap_left;
  int unsigned stall_left;
  bit          rx_fast;
  int unsigned errors;
  int unsigned bytes_sent;
  int unsigned msgs_sent;
  int unsigned chars_seen;
  int unsigned cycles;

  function automatic logic [7:0] b64_symbol(logic [5:0] s);
    if (s < 6'd26) return CHAR_UPPER_A + {2'b00, s};
    if (s < 6'd52) return CHAR_LOWER_A + {2'b00, s - 6'd26};
    if (s < 6'd62) return CHAR_DIGIT_0 + {2'b00, s - 6'd52};
    if (s == 6'd62) return CHAR_PLUS;
    return CHAR_SLASH;
  endfunction

  function automatic void encode_byte(logic [7:0] b, logic fin);
    b64_char_t seq[$];
    case (grp_pos)
      POS_SECOND: begin
        seq.push_back('{b64_symbol({carry_bits[1:0], b[7:4]}), 1'b0});
        carry_bits = b[3:0];
        grp_pos = POS_THIRD;
        if (fin) begin
          seq.push_back('{b64_symbol({b[3:0], 2'b00}), 1'b0});
          seq.push_back('{CHAR_PAD, 1'b0});
        end
      end
      POS_THIRD: begin
        seq.push_back('{b64_symbol({carry_bits, b[7:6]}), 1'b0});
        seq.push_back('{b64_symbol(b[5:0]), 1'b0});
        carry_bits = 4'd0;
        grp_pos = POS_FIRST;
      end
      default: begin
        seq.push_back('{b64_symbol(b[7:2]), 1'b0});
        carry_bits = {2'b00, b[1:0]};
        grp_pos = POS_SECOND;
        if (fin) begin
          seq.push_back('{b64_symbol({b[1:0], 4'b0000}), 1'b0});
          seq.push_back('{CHAR_PAD, 1'b0});
          seq.push_back('{CHAR_PAD, 1'b0});
        end
      end
    endcase
    if (fin) begin
      seq[seq.size() - 1].fin = 1'b1;
      grp_pos = POS_FIRST;
      carry_bits = 4'd0;
    end
    foreach (seq[i]) chars_due.push_back(seq[i]);
  endfunction

  function automatic void add_byte(logic [7:0] data, logic fin, int unsigned gap, bit drain);
    byte_queue.push_back('{data, fin, gap, drain});
  endfunction

  always @(posedge clk or negedge rst_n) begin
    byte_req_t nxt;
    if (!rst_n) begin
      byte_if.valid <= 1'b0;
      byte_if.in_byte <= 8'd0;
      byte_if.in_last <= 1'b0;
      in_flight = 1'b0;
      gap_left = 0;
    end else begin
      if (in_flight && byte_if.ready) begin
        encode_byte(byte_if.in_byte, byte_if.in_last);
        bytes_sent++;
        if (byte_if.in_last) msgs_sent++;
        in_flight = 1'b0;
      end
      if (!in_flight) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (byte_queue.size() > 0 &&
                     !(byte_queue[0].drain && chars_due.size() > 0)) begin
          if (byte_queue[0].gap > 0) begin
            gap_left = byte_queue[0].gap - 1;
            byte_queue[0].gap = 0;
          end else begin
            nxt = byte_queue.pop_front();
            byte_if.in_byte <= nxt.data;
            byte_if.in_last <= nxt.fin;
            in_flight = 1'b1;
          end
        end
      end
      byte_if.valid <= in_flight;
    end
  end

  always @(posedge clk or negedge rst_n) begin
    b64_char_t want;
    if (!rst_n) begin
      char_if.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (char_if.valid && char_if.ready) begin
        chars_seen++;
        if (chars_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected character, expected none, got char %h last %b",
                   $time, char_if.out_char, char_if.out_last);
        end else begin
          want = chars_due.pop_front();
          if (char_if.out_char !== want.ch) begin
            errors++;
            $display("%0t: out_char mismatch, expected %h, got %h",
                     $time, want.ch, char_if.out_char);
          end
          if (char_if.out_last !== want.fin) begin
            errors++;
            $display("%0t: out_last mismatch, expected %b, got %b",
                     $time, want.fin, char_if.out_last);
          end
        end
        stall_left = rx_fast ? 0 : $urandom_range(0, 7);
        if (chars_seen % 32 == 0) rx_fast = ($urandom_range(0, 2) == 0);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      char_if.ready <= (stall_left == 0);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d bytes queued and %0d characters outstanding",
               $time, byte_queue.size(), chars_due.size());
      $display("** base64_stream_encoder: FAILED **");
      $finish;
    end
  end

  initial begin
    int unsigned total;
    int unsigned len;
    int unsigned r;
    bit          fast;
    bit          mid_done;
    rst_n = 1'b0;

    // One-byte messages at both extremes.
    add_byte(8'h00, 1'b1, 0, 1'b0);
    add_byte(8'hFF, 1'b1, $urandom_range(0, 7), 1'b0);
    // Two-byte message, so the last byte sits in the middle of a group.
    add_byte(8'hFF, 1'b0, 0, 1'b0);
    add_byte(8'h00, 1'b1, 0, 1'b0);
    // Full group with no padding.
    add_byte(8'h4D, 1'b0, $urandom_range(0, 7), 1'b0);
    add_byte(8'h61, 1'b0, 0, 1'b0);
    add_byte(8'h6E, 1'b1, 0, 1'b0);
    // Plus and slash characters, then zeros, ending on a group boundary.
    add_byte(8'hFB, 1'b0, 0, 1'b0);
    add_byte(8'hFF, 1'b0, 0, 1'b0);
    add_byte(8'hBF, 1'b0, 0, 1'b0);
    add_byte(8'h00, 1'b0, 0, 1'b0);
    add_byte(8'h00, 1'b0, 0, 1'b0);
    add_byte(8'h00, 1'b1, $urandom_range(0, 7), 1'b0);
    // Last byte at the start of a second group.
    add_byte(8'hFC, 1'b0, 0, 1'b0);
    add_byte(8'h0F, 1'b0, 0, 1'b0);
    add_byte(8'hC0, 1'b0, 0, 1'b0);
    add_byte(8'hFF, 1'b1, 0, 1'b0);
    // Last byte in the middle of a second group.
    add_byte(8'h02, 1'b0, 0, 1'b0);
    add_byte(8'h7F, 1'b0, 0, 1'b0);
    add_byte(8'h80, 1'b0, 0, 1'b0);
    add_byte(8'h01, 1'b0, 0, 1'b0);
    add_byte(8'hFE, 1'b1, 0, 1'b0);

    total = 0;
    mid_done = 1'b0;
    while (total < RANDOM_BYTES) begin
      r = $urandom_range(0, 9);
      if (r < 7) len = $urandom_range(1, 6);
      else if (r < 9) len = $urandom_range(7, 20);
      else len = $urandom_range(30, 48);
      fast = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < len; i++) begin
        add_byte(8'($urandom_range(0, 255)), i == len - 1, fast ? 0 : $urandom_range(0, 7),
                 i == 0 && (total == 0 || (total >= RANDOM_BYTES / 2 && !mid_done)));
        if (i == 0 && total >= RANDOM_BYTES / 2) mid_done = 1'b1;
      end
      total += len;
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (byte_queue.size() != 0 || in_flight || chars_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Encoded %0d bytes in %0d messages and checked %0d characters,",
             bytes_sent, msgs_sent, chars_seen);
    $display("with random valid gaps, ready stalls and %0d mismatches.", errors);
    if (errors == 0) begin
      $display("** base64_stream_encoder: PASSED **");
    end else begin
      $display("** base64_stream_encoder: FAILED **");
    end
    $finish;
  end

endmodule

[sim.f]
sv/b64e_pkg.sv
sv/b64e_byte_if.sv
sv/b64e_char_if.sv
sv/b64e_front.sv
sv/b64e_fifo.sv
sv/b64e_back.sv
sv/base64_stream_encoder.sv
verif/tb.sv
